>>> hdl/wdnh_pkg.sv
// ----------------------------------------------------------------------------
// wdnh_pkg
// types and constants shared by the windowed depth normalize histogram block
// ----------------------------------------------------------------------------
package wdnh_pkg;

	localparam int LANES   = 4;
	localparam int SCALE_W = 25;
	localparam int CFG_W   = 25;
	localparam int IDX_W   = 3;

	localparam logic [1:0] CMD_LOCUS   = 2'd0;
	localparam logic [1:0] CMD_START   = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_IGNORED = 2'd3;

	localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
	localparam logic [IDX_W-1:0] REG_NORM_MASK     = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_LEVEL     = 3'd2;
	localparam logic [IDX_W-1:0] REG_BINS_PER_UNIT = 3'd3;
	localparam logic [IDX_W-1:0] REG_SCALE0        = 3'd4;
	localparam logic [IDX_W-1:0] REG_SCALE1        = 3'd5;
	localparam logic [IDX_W-1:0] REG_SCALE2        = 3'd6;
	localparam logic [IDX_W-1:0] REG_SCALE3        = 3'd7;

	localparam logic [2:0] SEL_LOCAL_AVG = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] depth_sample0;
		logic [15:0] depth_sample1;
		logic [15:0] depth_sample2;
		logic [15:0] depth_sample3;
		logic [2:0]  histogram_select;
		logic [9:0]  bin_number;
	} in_item_t;

	typedef struct packed {
		logic        is_readout;
		logic [15:0] ratio_sample0;
		logic [15:0] ratio_sample1;
		logic [15:0] ratio_sample2;
		logic [15:0] ratio_sample3;
		logic [15:0] local_average;
		logic [31:0] bin_count;
	} out_item_t;

endpackage

>>> hdl/windowed_depth_normalize_histogram.sv
// ----------------------------------------------------------------------------
// windowed_depth_normalize_histogram
// sliding-window depth sums per sample, q8.8 normalization and histograms
// ----------------------------------------------------------------------------
// A locus transaction updates the window sums, scales and averages the
// samples and forms each ratio; each quotient that is not settled directly
// (the local average and each ratio) comes from the shared 16-step radix-2
// divider, and each bin is counted by a read-modify-write of the histogram
// memory. A locus that does not fill the window returns to idle with no
// result. After reset and after a start command all (SAMPLES+1)*BINS entries
// of the histogram memory are cleared; no transaction is accepted meanwhile.
module windowed_depth_normalize_histogram #(
	parameter int SAMPLES    = 4,
	parameter int WINDOW_MAX = 256,
	parameter int BINS       = 1024,
	parameter int DEPTH_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  wdnh_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output wdnh_pkg::out_item_t          out_data,
	input  logic                         cfg_we,
	input  logic [wdnh_pkg::IDX_W-1:0]   cfg_index,
	input  logic [wdnh_pkg::CFG_W-1:0]   cfg_data
);

	localparam int LW    = $clog2(WINDOW_MAX + 1);
	localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SW    = DEPTH_BITS + LW;
	localparam int PRW   = SW + wdnh_pkg::SCALE_W;
	localparam int WW    = PRW - 16;
	localparam int NW    = WW + 8;
	localparam int NSW   = WW + 2;
	localparam int CW    = (NW > 32) ? NW : 32;
	localparam int BW    = $clog2(BINS);
	localparam int HDEPTH = (SAMPLES + 1) * BINS;
	localparam int HAW   = $clog2(HDEPTH);
	localparam int HW    = SAMPLES * DEPTH_BITS;

	typedef enum logic [12:0] {
		S_CLR  = 13'b0000000000001,
		S_IDLE = 13'b0000000000010,
		S_SUM  = 13'b0000000000100,
		S_MUL  = 13'b0000000001000,
		S_MACC = 13'b0000000010000,
		S_AVG  = 13'b0000000100000,
		S_DIVA = 13'b0000001000000,
		S_RAT  = 13'b0000010000000,
		S_DIVR = 13'b0000100000000,
		S_HRD  = 13'b0001000000000,
		S_HWR  = 13'b0010000000000,
		S_RDD  = 13'b0100000000000,
		S_OUT  = 13'b1000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [8:0]  wl_q;
	logic [3:0]  mask_q;
	logic [15:0] min_q;
	logic [6:0]  bpu_q;
	logic [wdnh_pkg::SCALE_W-1:0] scale_q [wdnh_pkg::LANES];

	// window state
	logic [SW-1:0]         sums_q [wdnh_pkg::LANES];
	logic [LW-1:0]         fill_q;
	logic [PW-1:0]         wp_q;
	logic [DEPTH_BITS-1:0] din_q [wdnh_pkg::LANES];

	// memories
	logic [HW-1:0]  hist_mem [WINDOW_MAX];
	logic [HW-1:0]  dh_rd_q;
	logic [31:0]    bin_mem [HDEPTH];
	logic [31:0]    bin_rd_q;

	// datapath
	logic [2:0]      idx_q;
	logic [PRW-1:0]  prod_s1;
	logic [WW-1:0]   w_q [wdnh_pkg::LANES];
	logic [NSW-1:0]  nsum_q;
	logic [2:0]      ncnt_q;
	logic [15:0]     avg_q;
	logic [15:0]     r_q [wdnh_pkg::LANES];
	logic [HAW-1:0]  haddr_s1;
	logic [HAW-1:0]  clr_q;
	logic            rd_ok_q;
	logic            readout_q;
	logic [31:0]     bin_q;

	// divider
	logic [15:0] dv_rem_q;
	logic [15:0] dv_num_q;
	logic [15:0] dv_den_q;
	logic [15:0] dv_quo_q;
	logic [4:0]  dv_cnt_q;
	logic [16:0] dv_t;
	logic        dv_ge;
	logic [15:0] dv_quo_next;

	logic            out_valid_q;
	wdnh_pkg::out_item_t out_q;

	logic [LW-1:0]  l_eff;
	logic [PW-1:0]  old_addr;
	logic           accept;
	logic [1:0]     lane;
	logic [WW-1:0]  wsat;
	logic [NW-1:0]  rnum;
	logic           r_sat;
	logic [15:0]    hval;
	logic [22:0]    hprod;
	logic [BW-1:0]  hbin;
	logic [HAW-1:0] tally_addr;
	logic           rd_ok;
	logic [HAW-1:0] rd_addr;
	logic [LW-1:0]  fill_next;
	logic           h_we;
	logic [HAW-1:0] h_waddr;
	logic [31:0]    h_wdata;
	logic           h_re;
	logic [HAW-1:0] h_raddr;
	logic [HW-1:0]  dh_wdata;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign lane     = idx_q[1:0];

	always_comb begin
		if (wl_q == 9'd0) begin
			l_eff = LW'(1);
		end else if (32'(wl_q) > WINDOW_MAX) begin
			l_eff = LW'(WINDOW_MAX);
		end else begin
			l_eff = LW'(wl_q);
		end
	end

	always_comb begin
		if (32'(wp_q) >= 32'(l_eff)) begin
			old_addr = PW'(32'(wp_q) - 32'(l_eff));
		end else begin
			old_addr = PW'(32'(wp_q) + WINDOW_MAX - 32'(l_eff));
		end
	end

	assign fill_next = (fill_q < l_eff) ? fill_q + LW'(1) : fill_q;

	always_comb begin
		dh_wdata = '0;
		dh_wdata[0 +: DEPTH_BITS] = DEPTH_BITS'(in_data.depth_sample0);
		if (SAMPLES > 1) dh_wdata[(1 % SAMPLES)*DEPTH_BITS +: DEPTH_BITS] =
			DEPTH_BITS'(in_data.depth_sample1);
		if (SAMPLES > 2) dh_wdata[(2 % SAMPLES)*DEPTH_BITS +: DEPTH_BITS] =
			DEPTH_BITS'(in_data.depth_sample2);
		if (SAMPLES > 3) dh_wdata[(3 % SAMPLES)*DEPTH_BITS +: DEPTH_BITS] =
			DEPTH_BITS'(in_data.depth_sample3);
	end

	// depth history memory, read-first
	always_ff @(posedge clk) begin
		if (accept && in_data.command == wdnh_pkg::CMD_LOCUS) begin
			dh_rd_q <= hist_mem[old_addr];
			hist_mem[wp_q] <= dh_wdata;
		end
	end

	// ratio quotient preparation
	always_comb begin
		if (WW > 40 && (w_q[lane] >> 40) != '0) begin
			wsat = WW'({40{1'b1}});
		end else begin
			wsat = w_q[lane];
		end
		rnum  = {wsat, 8'h00};
		r_sat = CW'(rnum) >= CW'({avg_q, 16'h0000});
	end

	// histogram bin of current value
	always_comb begin
		hval  = (idx_q == 3'(SAMPLES)) ? avg_q : r_q[lane];
		hprod = 23'(hval) * 23'(bpu_q);
		if (32'(hprod >> 8) > BINS - 1) begin
			hbin = BW'(BINS - 1);
		end else begin
			hbin = BW'(hprod >> 8);
		end
		tally_addr = HAW'(32'(idx_q) * BINS + 32'(hbin));
	end

	always_comb begin
		rd_ok = 1'b0;
		rd_addr = '0;
		if (32'(in_data.bin_number) < BINS) begin
			if (32'(in_data.histogram_select) < SAMPLES) begin
				rd_ok   = 1'b1;
				rd_addr = HAW'(32'(in_data.histogram_select) * BINS +
					32'(in_data.bin_number));
			end else if (in_data.histogram_select == wdnh_pkg::SEL_LOCAL_AVG) begin
				rd_ok   = 1'b1;
				rd_addr = HAW'(SAMPLES * BINS + 32'(in_data.bin_number));
			end
		end
	end

	always_comb begin
		h_we    = 1'b0;
		h_waddr = haddr_s1;
		h_wdata = (bin_rd_q == 32'hFFFF_FFFF) ? bin_rd_q : bin_rd_q + 32'd1;
		h_re    = 1'b0;
		h_raddr = tally_addr;
		if (state_q == S_CLR) begin
			h_we    = 1'b1;
			h_waddr = clr_q;
			h_wdata = '0;
		end else if (state_q == S_HWR) begin
			h_we = 1'b1;
		end
		if (state_q == S_HRD) begin
			h_re = 1'b1;
		end else if (accept && in_data.command == wdnh_pkg::CMD_READ && rd_ok) begin
			h_re    = 1'b1;
			h_raddr = rd_addr;
		end
	end

	// histogram memory
	always_ff @(posedge clk) begin
		if (h_we) begin
			bin_mem[h_waddr] <= h_wdata;
		end
		if (h_re) begin
			bin_rd_q <= bin_mem[h_raddr];
		end
	end

	// divider step
	assign dv_t        = {dv_rem_q, dv_num_q[15]};
	assign dv_ge       = dv_t >= {1'b0, dv_den_q};
	assign dv_quo_next = {dv_quo_q[14:0], dv_ge};

	always_ff @(posedge clk) begin
		if (state_q == S_DIVA || state_q == S_DIVR) begin
			dv_rem_q <= dv_ge ? 16'(dv_t - {1'b0, dv_den_q}) : dv_t[15:0];
			dv_num_q <= {dv_num_q[14:0], 1'b0};
			dv_quo_q <= dv_quo_next;
		end
		if (state_q == S_AVG) begin
			dv_rem_q <= 16'(nsum_q >> 16);
			dv_num_q <= nsum_q[15:0];
			dv_den_q <= 16'(ncnt_q);
		end
		if (state_q == S_RAT) begin
			dv_rem_q <= 16'(rnum >> 16);
			dv_num_q <= rnum[15:0];
			dv_den_q <= avg_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= 9'd1;
			mask_q <= 4'd0;
			min_q  <= 16'd26;
			bpu_q  <= 7'd10;
			for (int s = 0; s < wdnh_pkg::LANES; s++) begin
				scale_q[s] <= wdnh_pkg::SCALE_W'(24'hFF_FFFF) + wdnh_pkg::SCALE_W'(1);
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				wdnh_pkg::REG_WINDOW_LENGTH: wl_q   <= cfg_data[8:0];
				wdnh_pkg::REG_NORM_MASK:     mask_q <= cfg_data[3:0];
				wdnh_pkg::REG_MIN_LEVEL:     min_q  <= cfg_data[15:0];
				wdnh_pkg::REG_BINS_PER_UNIT: bpu_q  <= cfg_data[6:0];
				wdnh_pkg::REG_SCALE0:        scale_q[0] <= cfg_data;
				wdnh_pkg::REG_SCALE1:        scale_q[1] <= cfg_data;
				wdnh_pkg::REG_SCALE2:        scale_q[2] <= cfg_data;
				wdnh_pkg::REG_SCALE3:        scale_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			din_q[0] <= DEPTH_BITS'(in_data.depth_sample0);
			din_q[1] <= DEPTH_BITS'(in_data.depth_sample1);
			din_q[2] <= DEPTH_BITS'(in_data.depth_sample2);
			din_q[3] <= DEPTH_BITS'(in_data.depth_sample3);
			rd_ok_q  <= rd_ok;
		end
		if (state_q == S_MUL) begin
			prod_s1 <= PRW'(sums_q[lane]) * PRW'(scale_q[lane]);
		end
		if (state_q == S_MACC) begin
			w_q[lane] <= WW'(prod_s1 >> 16);
		end
		if (state_q == S_HRD) begin
			haddr_s1 <= tally_addr;
		end
		if (state_q == S_RDD) begin
			bin_q <= rd_ok_q ? bin_rd_q : 32'd0;
		end
		if (state_q == S_SUM) begin
			bin_q <= 32'd0;
		end
		if (state_q == S_AVG) begin
			if (ncnt_q == 3'd0) begin
				avg_q <= 16'd256;
			end else if (CW'(nsum_q) >= CW'({ncnt_q, 16'h0000})) begin
				avg_q <= 16'hFFFF;
			end
		end
		if (state_q == S_DIVA && dv_cnt_q == 5'd15) begin
			avg_q <= dv_quo_next;
		end
		if (state_q == S_RAT) begin
			if (avg_q < min_q && wsat < WW'(128)) begin
				r_q[lane] <= 16'd0;
			end else if (avg_q == 16'd0) begin
				r_q[lane] <= (wsat != '0) ? 16'hFFFF : 16'd0;
			end else if (r_sat) begin
				r_q[lane] <= 16'hFFFF;
			end
		end
		if (state_q == S_DIVR && dv_cnt_q == 5'd15) begin
			r_q[lane] <= dv_quo_next;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			fill_q      <= '0;
			wp_q        <= '0;
			idx_q       <= '0;
			nsum_q      <= '0;
			ncnt_q      <= '0;
			dv_cnt_q    <= '0;
			readout_q   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < wdnh_pkg::LANES; s++) sums_q[s] <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we && cfg_index == wdnh_pkg::REG_WINDOW_LENGTH) begin
				fill_q <= '0;
				wp_q   <= '0;
				for (int s = 0; s < wdnh_pkg::LANES; s++) sums_q[s] <= '0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + HAW'(1);
					if (32'(clr_q) == HDEPTH - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (in_data.command)
							wdnh_pkg::CMD_LOCUS: begin
								wp_q    <= (32'(wp_q) == WINDOW_MAX - 1) ? '0 : wp_q + PW'(1);
								state_q <= S_SUM;
							end
							wdnh_pkg::CMD_START: begin
								fill_q  <= '0;
								wp_q    <= '0;
								clr_q   <= '0;
								for (int s = 0; s < wdnh_pkg::LANES; s++) sums_q[s] <= '0;
								state_q <= S_CLR;
							end
							wdnh_pkg::CMD_READ: begin
								readout_q <= 1'b1;
								state_q   <= S_RDD;
							end
							default: ;
						endcase
					end
				end
				S_SUM: begin
					for (int s = 0; s < SAMPLES; s++) begin
						sums_q[s] <= sums_q[s] + SW'(din_q[s]) -
							((fill_q >= l_eff) ? SW'(dh_rd_q[s*DEPTH_BITS +: DEPTH_BITS]) : SW'(0));
					end
					fill_q    <= fill_next;
					idx_q     <= '0;
					nsum_q    <= '0;
					ncnt_q    <= '0;
					readout_q <= 1'b0;
					state_q   <= (fill_next < l_eff) ? S_IDLE : S_MUL;
				end
				S_MUL: begin
					state_q <= S_MACC;
				end
				S_MACC: begin
					if (mask_q[lane]) begin
						nsum_q <= nsum_q + NSW'(prod_s1 >> 16);
						ncnt_q <= ncnt_q + 3'd1;
					end
					if (idx_q == 3'(SAMPLES - 1)) begin
						idx_q   <= '0;
						state_q <= S_AVG;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_MUL;
					end
				end
				S_AVG: begin
					dv_cnt_q <= '0;
					if (ncnt_q == 3'd0 || CW'(nsum_q) >= CW'({ncnt_q, 16'h0000})) begin
						state_q <= S_RAT;
					end else begin
						state_q <= S_DIVA;
					end
				end
				S_DIVA: begin
					dv_cnt_q <= dv_cnt_q + 5'd1;
					if (dv_cnt_q == 5'd15) begin
						state_q <= S_RAT;
					end
				end
				S_RAT: begin
					dv_cnt_q <= '0;
					if ((avg_q < min_q && wsat < WW'(128)) || avg_q == 16'd0 || r_sat) begin
						state_q <= S_HRD;
					end else begin
						state_q <= S_DIVR;
					end
				end
				S_DIVR: begin
					dv_cnt_q <= dv_cnt_q + 5'd1;
					if (dv_cnt_q == 5'd15) begin
						state_q <= S_HRD;
					end
				end
				S_HRD: begin
					state_q <= S_HWR;
				end
				S_HWR: begin
					if (idx_q == 3'(SAMPLES)) begin
						state_q <= S_OUT;
					end else if (idx_q == 3'(SAMPLES - 1)) begin
						idx_q   <= 3'(SAMPLES);
						state_q <= S_HRD;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_RAT;
					end
				end
				S_RDD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_q.is_readout    <= readout_q;
			out_q.bin_count     <= readout_q ? bin_q : 32'd0;
			out_q.local_average <= readout_q ? 16'd0 : avg_q;
			out_q.ratio_sample0 <= readout_q ? 16'd0 : r_q[0];
			out_q.ratio_sample1 <= (readout_q || SAMPLES < 2) ? 16'd0 : r_q[1];
			out_q.ratio_sample2 <= (readout_q || SAMPLES < 3) ? 16'd0 : r_q[2];
			out_q.ratio_sample3 <= (readout_q || SAMPLES < 4) ? 16'd0 : r_q[3];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= l_eff)
		else $error("fill count beyond window length");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !in_ready)
		else $error("transaction accepted during clearing pass");

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVA || state_q == S_DIVR) |-> dv_cnt_q <= 5'd15)
		else $error("divider ran past its last step");

	a_readout_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_readout |-> out_data.local_average == 16'd0)
		else $error("read result carries locus fields");

endmodule

>>> tb/windowed_depth_normalize_histogram_test.sv
// ----------------------------------------------------------------------------
// windowed_depth_normalize_histogram_test
// self-checking bench: a scoreboard class predicts every locus and readout
// result from its own copy of the window, the histograms and the registers;
// directed corner cases are followed by randomized phases with varied
// settings, random idling on both channels and a long output back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_depth_normalize_histogram_test;

	localparam int WIN_MAX    = 256;
	localparam int NBINS      = 1024;
	localparam int STALL_MAX  = 20000;
	localparam int HOLD_LEN   = 3000;

	class depth_norm_scoreboard;
		bit [8:0]  win_len;
		bit [3:0]  norm_mask;
		bit [15:0] min_level;
		bit [6:0]  bins_unit;
		bit [24:0] scale[wdnh_pkg::LANES];
		bit [15:0] history[WIN_MAX][wdnh_pkg::LANES];
		bit [23:0] sums[wdnh_pkg::LANES];
		int unsigned fill;
		int unsigned wptr;
		bit [31:0] counts[(wdnh_pkg::LANES+1)*NBINS];
		wdnh_pkg::out_item_t expected_q[$];
		int errors;
		int locus_results;
		int readouts;
		int nonzero_reads;

		function new();
			win_len   = 1;
			norm_mask = 0;
			min_level = 26;
			bins_unit = 10;
			foreach (scale[s]) scale[s] = 25'd16777216;
			clear_window();
			foreach (counts[i]) counts[i] = 0;
			errors = 0;
			locus_results = 0;
			readouts = 0;
			nonzero_reads = 0;
		endfunction

		function void clear_window();
			foreach (sums[s]) sums[s] = 0;
			fill = 0;
			wptr = 0;
		endfunction

		function void set_reg(bit [wdnh_pkg::IDX_W-1:0] idx, bit [wdnh_pkg::CFG_W-1:0] v);
			case (idx)
				wdnh_pkg::REG_WINDOW_LENGTH: begin
					win_len = v[8:0];
					clear_window();
				end
				wdnh_pkg::REG_NORM_MASK:     norm_mask = v[3:0];
				wdnh_pkg::REG_MIN_LEVEL:     min_level = v[15:0];
				wdnh_pkg::REG_BINS_PER_UNIT: bins_unit = v[6:0];
				wdnh_pkg::REG_SCALE0:        scale[0] = v;
				wdnh_pkg::REG_SCALE1:        scale[1] = v;
				wdnh_pkg::REG_SCALE2:        scale[2] = v;
				wdnh_pkg::REG_SCALE3:        scale[3] = v;
				default: ;
			endcase
		endfunction

		function void tally(int h, bit [15:0] v);
			bit [31:0] b;
			int idx;
			b = (32'(v) * 32'(bins_unit)) >> 8;
			if (b > NBINS - 1) b = NBINS - 1;
			idx = h * NBINS + int'(b);
			if (counts[idx] != 32'hFFFF_FFFF) counts[idx]++;
		endfunction

		function void note_input(wdnh_pkg::in_item_t it);
			bit [15:0] d[wdnh_pkg::LANES];
			bit [63:0] w[wdnh_pkg::LANES];
			bit [63:0] nsum;
			bit [63:0] q;
			int ncount;
			int unsigned wl;
			int unsigned oldest;
			bit [15:0] avg;
			wdnh_pkg::out_item_t r;
			int h;
			case (it.command)
				wdnh_pkg::CMD_START: begin
					clear_window();
					foreach (counts[i]) counts[i] = 0;
				end
				wdnh_pkg::CMD_READ: begin
					r = '0;
					r.is_readout = 1'b1;
					h = -1;
					if (it.histogram_select < wdnh_pkg::LANES) h = it.histogram_select;
					else if (it.histogram_select == wdnh_pkg::SEL_LOCAL_AVG) h = wdnh_pkg::LANES;
					if (h >= 0 && it.bin_number < NBINS)
						r.bin_count = counts[h * NBINS + it.bin_number];
					expected_q.push_back(r);
				end
				wdnh_pkg::CMD_LOCUS: begin
					wl = win_len < 1 ? 1 : (win_len > WIN_MAX ? WIN_MAX : win_len);
					oldest = (wptr + WIN_MAX - wl) % WIN_MAX;
					d[0] = it.depth_sample0;
					d[1] = it.depth_sample1;
					d[2] = it.depth_sample2;
					d[3] = it.depth_sample3;
					for (int s = 0; s < wdnh_pkg::LANES; s++) begin
						if (fill >= wl) sums[s] -= 24'(history[oldest][s]);
						sums[s] += 24'(d[s]);
						history[wptr][s] = d[s];
					end
					wptr = (wptr + 1) % WIN_MAX;
					if (fill < wl) fill++;
					if (fill >= wl) begin
						nsum = 0;
						ncount = 0;
						for (int s = 0; s < wdnh_pkg::LANES; s++) begin
							w[s] = (64'(sums[s]) * 64'(scale[s])) >> 16;
							if (norm_mask[s]) begin
								nsum += w[s];
								ncount++;
							end
						end
						if (ncount == 0) avg = 16'd256;
						else begin
							q = nsum / ncount;
							avg = q > 64'hFFFF ? 16'hFFFF : q[15:0];
						end
						r = '0;
						for (int s = 0; s < wdnh_pkg::LANES; s++) begin
							bit [15:0] ratio;
							if (avg < min_level && w[s] < 128) ratio = 0;
							else if (avg == 0) ratio = w[s] > 0 ? 16'hFFFF : 16'h0;
							else begin
								q = w[s] > 64'hFF_FFFF_FFFF ? 64'hFF_FFFF_FFFF : w[s];
								q = (q << 8) / avg;
								ratio = q > 64'hFFFF ? 16'hFFFF : q[15:0];
							end
							tally(s, ratio);
							case (s)
								0: r.ratio_sample0 = ratio;
								1: r.ratio_sample1 = ratio;
								2: r.ratio_sample2 = ratio;
								default: r.ratio_sample3 = ratio;
							endcase
						end
						tally(wdnh_pkg::LANES, avg);
						r.local_average = avg;
						expected_q.push_back(r);
					end
				end
				default: ;
			endcase
		endfunction

		function void compare(string name, longint unsigned exp_v, longint unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(wdnh_pkg::out_item_t got);
			wdnh_pkg::out_item_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction: %h", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare("is_readout", e.is_readout, got.is_readout);
			compare("ratio_sample0", e.ratio_sample0, got.ratio_sample0);
			compare("ratio_sample1", e.ratio_sample1, got.ratio_sample1);
			compare("ratio_sample2", e.ratio_sample2, got.ratio_sample2);
			compare("ratio_sample3", e.ratio_sample3, got.ratio_sample3);
			compare("local_average", e.local_average, got.local_average);
			compare("bin_count", e.bin_count, got.bin_count);
			if (e.is_readout) begin
				readouts++;
				if (e.bin_count != 0) nonzero_reads++;
			end else begin
				locus_results++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	wdnh_pkg::in_item_t            in_data;
	logic                          out_valid;
	logic                          out_ready;
	wdnh_pkg::out_item_t           out_data;
	logic                          cfg_we;
	logic [wdnh_pkg::IDX_W-1:0]    cfg_index;
	logic [wdnh_pkg::CFG_W-1:0]    cfg_data;

	depth_norm_scoreboard sb;
	int tx_idle;
	int rx_idle;
	int settings_used;
	int stall_cycles;
	bit held;

	windowed_depth_normalize_histogram u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side: random idling plus one long hold-off
	initial begin
		out_ready = 1'b0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sb != null && sb.locus_results + sb.readouts >= 300) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("timeout: no transaction for %0d cycles", STALL_MAX);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send(wdnh_pkg::in_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
	endtask

	task automatic write_reg(logic [wdnh_pkg::IDX_W-1:0] idx,
			logic [wdnh_pkg::CFG_W-1:0] v);
		@(negedge clk);
		in_valid  <= 1'b0;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// drain results, then let any silent work and a clearing pass finish
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		while (!in_ready) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic wdnh_pkg::in_item_t locus(bit [15:0] d0, bit [15:0] d1,
			bit [15:0] d2, bit [15:0] d3);
		wdnh_pkg::in_item_t it;
		it = '0;
		it.command = wdnh_pkg::CMD_LOCUS;
		it.depth_sample0 = d0;
		it.depth_sample1 = d1;
		it.depth_sample2 = d2;
		it.depth_sample3 = d3;
		it.histogram_select = 3'($urandom());
		it.bin_number = 10'($urandom());
		return it;
	endfunction

	function automatic wdnh_pkg::in_item_t bin_read(bit [2:0] sel, bit [9:0] bn);
		wdnh_pkg::in_item_t it;
		it = wdnh_pkg::in_item_t'({$urandom(), $urandom(), $urandom()});
		it.command = wdnh_pkg::CMD_READ;
		it.histogram_select = sel;
		it.bin_number = bn;
		return it;
	endfunction

	function automatic wdnh_pkg::in_item_t plain_cmd(bit [1:0] c);
		wdnh_pkg::in_item_t it;
		it = wdnh_pkg::in_item_t'({$urandom(), $urandom(), $urandom()});
		it.command = c;
		return it;
	endfunction

	function automatic bit [15:0] depth_value(int base);
		case ($urandom_range(0, 11))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom());
			default: return 16'(base - base / 4 + $urandom_range(0, base / 2));
		endcase
	endfunction

	task automatic random_phase(int win, int base, int n);
		int m;
		int bpu;
		m = $urandom_range(0, 15);
		write_reg(wdnh_pkg::REG_WINDOW_LENGTH, 25'(win));
		write_reg(wdnh_pkg::REG_NORM_MASK, 25'(m));
		case ($urandom_range(0, 4))
			0: write_reg(wdnh_pkg::REG_MIN_LEVEL, 25'd0);
			1: write_reg(wdnh_pkg::REG_MIN_LEVEL, 25'h0FFFF);
			default: write_reg(wdnh_pkg::REG_MIN_LEVEL, 25'($urandom_range(0, 600)));
		endcase
		case ($urandom_range(0, 5))
			0: bpu = 0;
			1: bpu = 127;
			2: bpu = 64;
			default: bpu = $urandom_range(1, 64);
		endcase
		write_reg(wdnh_pkg::REG_BINS_PER_UNIT, 25'(bpu));
		for (int s = 0; s < wdnh_pkg::LANES; s++) begin
			int eff;
			logic [wdnh_pkg::CFG_W-1:0] sc;
			eff = win < 1 ? 1 : (win > WIN_MAX ? WIN_MAX : win);
			case ($urandom_range(0, 9))
				0: sc = '0;
				1: sc = 25'd16777216;
				2: sc = 25'($urandom());
				default: sc = 25'(32'd16777216 / 32'(base * eff));
			endcase
			write_reg(3'(int'(wdnh_pkg::REG_SCALE0) + s), sc);
		end
		settings_used++;
		for (int i = 0; i < n; i++) begin
			int roll;
			roll = $urandom_range(0, 199);
			if (roll < 160)
				send(locus(depth_value(base), depth_value(base), depth_value(base),
					depth_value(base)));
			else if (roll < 192)
				send(bin_read($urandom_range(0, 9) < 8 ? 3'($urandom_range(0, 4))
						: 3'($urandom_range(5, 7)),
					$urandom_range(0, 1) ? 10'($urandom_range(0, 2 * bpu + 4))
						: 10'($urandom_range(0, 1023))));
			else if (roll < 198)
				send(plain_cmd(wdnh_pkg::CMD_IGNORED));
			else
				send(plain_cmd(wdnh_pkg::CMD_START));
		end
		settle();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle = 29;
		rx_idle = 54;
		settings_used = 1;
		stall_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		settle();

		// reset settings: window of one, no normalizers
		send(locus(16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send(locus(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send(locus(16'd1, 16'd256, 16'h8000, 16'd17));
		send(bin_read(3'd0, 10'd0));
		send(bin_read(wdnh_pkg::SEL_LOCAL_AVG, 10'd10));
		send(bin_read(3'd1, 10'd1023));
		send(bin_read(3'd5, 10'd0));
		send(bin_read(3'd7, 10'd1023));
		send(plain_cmd(wdnh_pkg::CMD_IGNORED));
		send(plain_cmd(wdnh_pkg::CMD_START));
		send(bin_read(wdnh_pkg::SEL_LOCAL_AVG, 10'd10));
		settle();

		// zero local average: the normalizer scale is zero, the others are not
		write_reg(wdnh_pkg::REG_WINDOW_LENGTH, 25'd0);
		write_reg(wdnh_pkg::REG_NORM_MASK, 25'b0001);
		write_reg(wdnh_pkg::REG_MIN_LEVEL, 25'd0);
		write_reg(wdnh_pkg::REG_BINS_PER_UNIT, 25'd0);
		write_reg(wdnh_pkg::REG_SCALE0, 25'd0);
		write_reg(wdnh_pkg::REG_SCALE1, 25'h1FFFFFF);
		write_reg(wdnh_pkg::REG_SCALE2, 25'd16777216);
		write_reg(wdnh_pkg::REG_SCALE3, 25'd1);
		settings_used++;
		send(locus(16'd500, 16'd500, 16'd0, 16'hFFFF));
		send(locus(16'hFFFF, 16'd1, 16'd3, 16'd0));
		send(bin_read(3'd1, 10'd0));
		send(bin_read(wdnh_pkg::SEL_LOCAL_AVG, 10'd0));
		settle();
		write_reg(wdnh_pkg::REG_NORM_MASK, 25'b1111);
		write_reg(wdnh_pkg::REG_MIN_LEVEL, 25'h0FFFF);
		write_reg(wdnh_pkg::REG_WINDOW_LENGTH, 25'd2);
		send(locus(16'd10, 16'd20, 16'd30, 16'd40));
		send(locus(16'd0, 16'hFFFF, 16'd0, 16'd1));
		send(locus(16'd7, 16'd0, 16'hFFFF, 16'd2));
		send(bin_read(3'd3, 10'd0));
		settle();

		for (int p = 0; p < 9; p++) begin
			int win;
			int n;
			tx_idle = p < 3 ? 29 : (p < 6 ? 54 : 0);
			rx_idle = p < 3 ? 54 : (p < 6 ? 29 : 0);
			if (p == 4) win = 256;
			else if (p == 7) win = $urandom_range(257, 511);
			else if ($urandom_range(0, 9) < 7) win = $urandom_range(1, 8);
			else win = $urandom_range(9, 40);
			n = win > 40 ? 316 : 100;
			random_phase(win, $urandom_range(1, 1000), n);
		end

		settle();
		$display("checked %0d locus results and %0d bin reads (%0d nonzero)",
			sb.locus_results, sb.readouts, sb.nonzero_reads);
		$display("over %0d register settings with idling, back-pressure and clears",
			settings_used);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
